// File: rtl/trslmb_pkg.sv
// Shared types and constants for the TRS local matrix builder.
`timescale 1ns / 1ps

package trslmb_pkg;

	localparam int NLANE      = 9;                   // rotation entries per item
	localparam int QBITS      = 18;                  // quotient bits, q <= 2^17
	localparam int ABITS      = 50;                  // dividend: mag*2^18 + n
	localparam int NBITS      = 33;                  // squared norm, unsigned
	localparam int DBITS      = NBITS + 1;           // divisor 2n
	localparam int RBITS      = ABITS + 1;           // partial remainder
	localparam int DIV_STAGES = QBITS;
	localparam int PBITS      = 50;                  // r (18b) * scale (32b)

	localparam logic signed [QBITS-1:0] ONE_R = 18'sd65536;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m03;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m13;
		logic signed [31:0] m20;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
		logic signed [31:0] m23;
	} out_t;

	typedef struct packed {
		logic             zero;
		logic [NLANE-1:0] neg;
		in_t              item;
	} side_t;

endpackage

// File: rtl/trslmb_div.sv
// Pipelined restoring divider, one quotient bit per stage, nine lanes sharing a divisor.
`timescale 1ns / 1ps

module trslmb_div (
	input  logic                                              clk,
	input  logic [trslmb_pkg::NLANE-1:0][trslmb_pkg::ABITS-1:0] a,
	input  logic [trslmb_pkg::DBITS-1:0]                      d,
	output logic [trslmb_pkg::NLANE-1:0][trslmb_pkg::QBITS-1:0] q
);

	logic [trslmb_pkg::NLANE-1:0][trslmb_pkg::RBITS-1:0] rem_s [trslmb_pkg::DIV_STAGES+1];
	logic [trslmb_pkg::NLANE-1:0][trslmb_pkg::QBITS-1:0] quo_s [trslmb_pkg::DIV_STAGES+1];
	logic [trslmb_pkg::DBITS-1:0]                        dvs_s [trslmb_pkg::DIV_STAGES+1];

	always_comb begin
		for (int l = 0; l < trslmb_pkg::NLANE; l++) begin
			rem_s[0][l] = {1'b0, a[l]};
			quo_s[0][l] = '0;
		end
		dvs_s[0] = d;
	end

	for (genvar k = 0; k < trslmb_pkg::DIV_STAGES; k++) begin : g_stage
		localparam int B = trslmb_pkg::DIV_STAGES - 1 - k;
		logic [trslmb_pkg::RBITS-1:0] dsh;
		assign dsh = {{(trslmb_pkg::RBITS-trslmb_pkg::DBITS){1'b0}}, dvs_s[k]} << B;

		always_ff @(posedge clk) begin
			for (int l = 0; l < trslmb_pkg::NLANE; l++) begin
				if (rem_s[k][l] >= dsh) begin
					rem_s[k+1][l] <= rem_s[k][l] - dsh;
					quo_s[k+1][l] <= {quo_s[k][l][trslmb_pkg::QBITS-2:0], 1'b1};
				end else begin
					rem_s[k+1][l] <= rem_s[k][l];
					quo_s[k+1][l] <= {quo_s[k][l][trslmb_pkg::QBITS-2:0], 1'b0};
				end
			end
			dvs_s[k+1] <= dvs_s[k];
		end
	end

	assign q = quo_s[trslmb_pkg::DIV_STAGES];

endmodule

// File: rtl/trs_local_matrix_builder.sv
// Top level: builds rows 0..2 of T*R*S from position, quaternion and scale.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive cmd and pulse start; an item is taken at any edge with
//   start high and busy low. busy is always low: a new item may enter every cycle.
//   Result channel: done is high for one cycle with res holding the 3x4 matrix.
//   The receiver cannot stall and none is needed; results leave in order.
// Path: input register, products, sums, dividend setup, 18 divider stages,
//   rotation entry, scale multiply and round/saturate lead from the accepting
//   edge to done. Throughput: one item per cycle.
// The rate is set by the nine-lane divider, which retires one quotient bit per
//   stage so each stage is a single 51-bit compare and subtract.
// Quaternion need not be unit length; each entry is an exact rounded ratio
//   against its squared norm. A zero quaternion yields identity rotation.
// Reset clears the valid pipeline only; items in flight at reset are dropped.

module trs_local_matrix_builder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  trslmb_pkg::in_t    cmd,
	output logic               done,
	output trslmb_pkg::out_t   res
);

	localparam int NL = trslmb_pkg::NLANE;
	localparam int DS = trslmb_pkg::DIV_STAGES;

	assign busy = 1'b0;

	// stage 1: input capture
	logic            v_s1;
	trslmb_pkg::in_t in_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		in_s1 <= cmd;
	end

	// stage 2: quaternion products
	logic                v_s2;
	trslmb_pkg::in_t     in_s2;
	logic signed [31:0]  xx_s2, yy_s2, zz_s2, ww_s2, xy_s2, xz_s2, yz_s2, wx_s2, wy_s2, wz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		in_s2 <= in_s1;
		xx_s2 <= in_s1.quat_x * in_s1.quat_x;
		yy_s2 <= in_s1.quat_y * in_s1.quat_y;
		zz_s2 <= in_s1.quat_z * in_s1.quat_z;
		ww_s2 <= in_s1.quat_w * in_s1.quat_w;
		xy_s2 <= in_s1.quat_x * in_s1.quat_y;
		xz_s2 <= in_s1.quat_x * in_s1.quat_z;
		yz_s2 <= in_s1.quat_y * in_s1.quat_z;
		wx_s2 <= in_s1.quat_w * in_s1.quat_x;
		wy_s2 <= in_s1.quat_w * in_s1.quat_y;
		wz_s2 <= in_s1.quat_w * in_s1.quat_z;
	end

	// stage 3: numerators and squared norm
	logic                                v_s3;
	trslmb_pkg::in_t                     in_s3;
	logic signed [trslmb_pkg::NBITS-1:0] num_s3 [NL];
	logic        [trslmb_pkg::NBITS-1:0] n_s3;
	logic signed [trslmb_pkg::NBITS-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;

	assign exx = trslmb_pkg::NBITS'(xx_s2);
	assign eyy = trslmb_pkg::NBITS'(yy_s2);
	assign ezz = trslmb_pkg::NBITS'(zz_s2);
	assign eww = trslmb_pkg::NBITS'(ww_s2);
	assign exy = trslmb_pkg::NBITS'(xy_s2);
	assign exz = trslmb_pkg::NBITS'(xz_s2);
	assign eyz = trslmb_pkg::NBITS'(yz_s2);
	assign ewx = trslmb_pkg::NBITS'(wx_s2);
	assign ewy = trslmb_pkg::NBITS'(wy_s2);
	assign ewz = trslmb_pkg::NBITS'(wz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		in_s3     <= in_s2;
		n_s3      <= exx + eyy + ezz + eww;
		num_s3[0] <= eyy + ezz;
		num_s3[1] <= exy - ewz;
		num_s3[2] <= exz + ewy;
		num_s3[3] <= exy + ewz;
		num_s3[4] <= exx + ezz;
		num_s3[5] <= eyz - ewx;
		num_s3[6] <= exz - ewy;
		num_s3[7] <= eyz + ewx;
		num_s3[8] <= exx + eyy;
	end

	// stage 4: dividend mag*2^18 + n, divisor 2n (round half away from zero)
	logic                                            v_s4;
	trslmb_pkg::side_t                               sd_s4;
	logic [NL-1:0][trslmb_pkg::ABITS-1:0]            a_s4;
	logic [trslmb_pkg::DBITS-1:0]                    d_s4;
	logic [NL-1:0][trslmb_pkg::NBITS-1:0]            mag3;

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			mag3[l] = num_s3[l][trslmb_pkg::NBITS-1] ? trslmb_pkg::NBITS'(-num_s3[l])
				: trslmb_pkg::NBITS'(num_s3[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sd_s4.item <= in_s3;
		sd_s4.zero <= (n_s3 == '0);
		for (int l = 0; l < NL; l++) begin
			sd_s4.neg[l] <= num_s3[l][trslmb_pkg::NBITS-1];
			a_s4[l] <= {mag3[l][31:0], 18'd0}
				+ {{(trslmb_pkg::ABITS-trslmb_pkg::NBITS){1'b0}}, n_s3};
		end
		d_s4 <= {n_s3, 1'b0};
	end

	// divider
	logic [NL-1:0][trslmb_pkg::QBITS-1:0] quo;

	trslmb_div u_div (
		.clk (clk),
		.a   (a_s4),
		.d   (d_s4),
		.q   (quo)
	);

	logic              v_dl  [DS];
	trslmb_pkg::side_t sd_dl [DS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DS; k++) v_dl[k] <= 1'b0;
		end else begin
			v_dl[0] <= v_s4;
			for (int k = 1; k < DS; k++) v_dl[k] <= v_dl[k-1];
		end
	end

	always_ff @(posedge clk) begin
		sd_dl[0] <= sd_s4;
		for (int k = 1; k < DS; k++) begin
			sd_dl[k] <= sd_dl[k-1];
		end
	end

	trslmb_pkg::side_t sd_q;
	assign sd_q = sd_dl[DS-1];

	// stage 5: rotation entries in signed Q1.16 (18-bit)
	logic                                v_s5;
	trslmb_pkg::in_t                     in_s5;
	logic signed [trslmb_pkg::QBITS-1:0] r_s5 [NL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_dl[DS-1];
		end
	end

	always_ff @(posedge clk) begin
		in_s5 <= sd_q.item;
		for (int l = 0; l < NL; l++) begin
			if (l % 4 == 0) begin
				r_s5[l] <= sd_q.zero ? trslmb_pkg::ONE_R
					: trslmb_pkg::ONE_R - $signed(quo[l]);
			end else if (sd_q.zero) begin
				r_s5[l] <= '0;
			end else begin
				r_s5[l] <= sd_q.neg[l] ? -$signed(quo[l]) : $signed(quo[l]);
			end
		end
	end

	// stage 6: scale by column
	logic                                v_s6;
	trslmb_pkg::in_t                     in_s6;
	logic signed [trslmb_pkg::PBITS-1:0] p_s6 [NL];
	logic signed [31:0]                  scl [3];

	assign scl[0] = in_s5.scale_x;
	assign scl[1] = in_s5.scale_y;
	assign scl[2] = in_s5.scale_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		in_s6 <= in_s5;
		for (int l = 0; l < NL; l++) begin
			p_s6[l] <= r_s5[l] * scl[l % 3];
		end
	end

	// stage 7: round by 2^16 and saturate
	logic signed [31:0]                  m [NL];
	logic        [trslmb_pkg::PBITS-1:0] pmag [NL];
	logic        [trslmb_pkg::PBITS-1:0] rq [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			pmag[l] = p_s6[l][trslmb_pkg::PBITS-1] ? trslmb_pkg::PBITS'(-p_s6[l])
				: trslmb_pkg::PBITS'(p_s6[l]);
			rq[l] = (pmag[l] + trslmb_pkg::PBITS'(32768)) >> 16;
			if (!p_s6[l][trslmb_pkg::PBITS-1]) begin
				m[l] = (rq[l] > trslmb_pkg::PBITS'(32'h7fff_ffff)) ? 32'sh7fff_ffff
					: $signed(rq[l][31:0]);
			end else begin
				m[l] = (rq[l] >= trslmb_pkg::PBITS'(33'h0_8000_0000)) ? 32'sh8000_0000
					: -$signed(rq[l][31:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		res.m00 <= m[0];
		res.m01 <= m[1];
		res.m02 <= m[2];
		res.m03 <= in_s6.pos_x;
		res.m10 <= m[3];
		res.m11 <= m[4];
		res.m12 <= m[5];
		res.m13 <= in_s6.pos_y;
		res.m20 <= m[6];
		res.m21 <= m[7];
		res.m22 <= m[8];
		res.m23 <= in_s6.pos_z;
	end

endmodule

// File: tb/tb_trs_local_matrix_builder.sv
// Testbench for the TRS local matrix builder: random and corner items checked against a predictor.
`timescale 1ns / 1ps

module tb_trs_local_matrix_builder;

	localparam int LATENCY   = 25;
	localparam int WDOG_MAX  = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	trslmb_pkg::in_t  cmd;
	logic done;
	trslmb_pkg::out_t res;

	trslmb_pkg::in_t  pending_items[$];
	trslmb_pkg::out_t expected_mats[$];
	int   n_errors;
	int   idle_cycles;
	int   gap_left;
	bit   hold_off;

	trs_local_matrix_builder u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .res(res)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// round to nearest, ties away from zero; den > 0
	function automatic longint div_round(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic trslmb_pkg::out_t build_matrix(trslmb_pkg::in_t it);
		longint x, y, z, w, n, k;
		longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
		longint rot[3][3];
		longint scl[3];
		longint m[3][3];
		trslmb_pkg::out_t o;
		x = it.quat_x; y = it.quat_y; z = it.quat_z; w = it.quat_w;
		scl[0] = it.scale_x; scl[1] = it.scale_y; scl[2] = it.scale_z;
		xx = x * x; yy = y * y; zz = z * z;
		xy = x * y; xz = x * z; yz = y * z;
		wx = w * x; wy = w * y; wz = w * z;
		n = xx + yy + zz + w * w;
		k = 131072;
		if (n == 0) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					rot[i][j] = (i == j) ? 65536 : 0;
		end else begin
			rot[0][0] = 65536 - div_round(k * (yy + zz), n);
			rot[0][1] = div_round(k * (xy - wz), n);
			rot[0][2] = div_round(k * (xz + wy), n);
			rot[1][0] = div_round(k * (xy + wz), n);
			rot[1][1] = 65536 - div_round(k * (xx + zz), n);
			rot[1][2] = div_round(k * (yz - wx), n);
			rot[2][0] = div_round(k * (xz - wy), n);
			rot[2][1] = div_round(k * (yz + wx), n);
			rot[2][2] = 65536 - div_round(k * (xx + yy), n);
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = div_round(rot[i][j] * scl[j], 65536);
		o.m00 = clamp32(m[0][0]); o.m01 = clamp32(m[0][1]); o.m02 = clamp32(m[0][2]);
		o.m10 = clamp32(m[1][0]); o.m11 = clamp32(m[1][1]); o.m12 = clamp32(m[1][2]);
		o.m20 = clamp32(m[2][0]); o.m21 = clamp32(m[2][1]); o.m22 = clamp32(m[2][2]);
		o.m03 = it.pos_x; o.m13 = it.pos_y; o.m23 = it.pos_z;
		return o;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("ERROR t=%0t %s got %h want %h", $realtime, field, got, want);
		n_errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] rand_quat();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 32) - 16);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] rand_scale();
		case ($urandom_range(0, 6))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h00010000;
			3: return $urandom_range(0, 32'h40000) - 32'h20000;
			default: return $urandom();
		endcase
	endfunction

	function automatic trslmb_pkg::in_t rand_item();
		trslmb_pkg::in_t it;
		it.pos_x = $urandom(); it.pos_y = $urandom(); it.pos_z = $urandom();
		it.quat_x = rand_quat(); it.quat_y = rand_quat();
		it.quat_z = rand_quat(); it.quat_w = rand_quat();
		if ($urandom_range(0, 19) == 0)
			{it.quat_x, it.quat_y, it.quat_z, it.quat_w} = '0;
		it.scale_x = rand_scale(); it.scale_y = rand_scale(); it.scale_z = rand_scale();
		return it;
	endfunction

	function automatic trslmb_pkg::in_t make_item(logic [31:0] p, logic [15:0] qx,
			logic [15:0] qy, logic [15:0] qz, logic [15:0] qw, logic [31:0] s);
		trslmb_pkg::in_t it;
		it.pos_x = p; it.pos_y = ~p; it.pos_z = p ^ 32'h5a5a5a5a;
		it.quat_x = qx; it.quat_y = qy; it.quat_z = qz; it.quat_w = qw;
		it.scale_x = s; it.scale_y = s; it.scale_z = s;
		return it;
	endfunction

	// driver: one item per start, random gaps, optional hold-off until drained
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				expected_mats.push_back(build_matrix(cmd));
				gap_left = pick_gap();
			end
			if (start && busy) begin
				// keep presenting
			end else if (hold_off && expected_mats.size() != 0) begin
				start <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_items.size() != 0) begin
				cmd <= pending_items.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				trslmb_pkg::out_t want;
				if (expected_mats.size() == 0) begin
					$display("ERROR t=%0t unexpected result", $realtime);
					n_errors++;
				end else begin
					want = expected_mats.pop_front();
					if (res.m00 !== want.m00) report_mismatch("m00", res.m00, want.m00);
					if (res.m01 !== want.m01) report_mismatch("m01", res.m01, want.m01);
					if (res.m02 !== want.m02) report_mismatch("m02", res.m02, want.m02);
					if (res.m03 !== want.m03) report_mismatch("m03", res.m03, want.m03);
					if (res.m10 !== want.m10) report_mismatch("m10", res.m10, want.m10);
					if (res.m11 !== want.m11) report_mismatch("m11", res.m11, want.m11);
					if (res.m12 !== want.m12) report_mismatch("m12", res.m12, want.m12);
					if (res.m13 !== want.m13) report_mismatch("m13", res.m13, want.m13);
					if (res.m20 !== want.m20) report_mismatch("m20", res.m20, want.m20);
					if (res.m21 !== want.m21) report_mismatch("m21", res.m21, want.m21);
					if (res.m22 !== want.m22) report_mismatch("m22", res.m22, want.m22);
					if (res.m23 !== want.m23) report_mismatch("m23", res.m23, want.m23);
				end
			end
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WDOG_MAX) begin
				$display("trs_local_matrix_builder: mismatch");
				$finish;
			end
		end
	end

	initial begin
		n_errors = 0;
		idle_cycles = 0;
		hold_off = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corners: identity, zero quaternion, extreme components, saturation
		pending_items.push_back(make_item(32'h0, 16'h0, 16'h0, 16'h0, 16'h4000, 32'h10000));
		pending_items.push_back(make_item(32'h7fffffff, 16'h0, 16'h0, 16'h0, 16'h0,
			32'h7fffffff));
		pending_items.push_back(make_item(32'h80000000, 16'h0, 16'h0, 16'h0, 16'h0,
			32'h80000000));
		pending_items.push_back(make_item(32'hffffffff, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 32'h7fffffff));
		pending_items.push_back(make_item(32'h1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			32'h80000000));
		pending_items.push_back(make_item(32'h12345678, 16'h7fff, 16'h0, 16'h0, 16'h0,
			32'h7fffffff));
		pending_items.push_back(make_item(32'h0, 16'h0, 16'h8000, 16'h0, 16'h0,
			32'h80000000));
		pending_items.push_back(make_item(32'h0, 16'h0, 16'h0, 16'h7fff, 16'h0, 32'hffffffff));
		pending_items.push_back(make_item(32'h0, 16'h0, 16'h0, 16'h0, 16'h1, 32'h1));
		pending_items.push_back(make_item(32'h0, 16'h1, 16'h0, 16'h0, 16'h1, 32'h8000));
		pending_items.push_back(make_item(32'h0, 16'h2d41, 16'h0, 16'h0, 16'h2d41,
			32'h7fffffff));
		pending_items.push_back(make_item(32'h0, 16'h2000, 16'h2000, 16'h2000, 16'h2000,
			32'h00028000));
		pending_items.push_back(make_item(32'h0, 16'hffff, 16'h1, 16'hffff, 16'h1, 32'h3));
		pending_items.push_back(make_item(32'haaaaaaaa, 16'h5555, 16'haaaa, 16'h5555,
			16'haaaa, 32'h55555555));
		pending_items.push_back(make_item(32'h55555555, 16'haaaa, 16'h5555, 16'haaaa,
			16'h5555, 32'haaaaaaaa));
		for (int i = 0; i < 250; i++)
			pending_items.push_back(rand_item());
		wait (pending_items.size() == 0 && !start);

		// drain fully once before resuming
		hold_off = 1;
		wait (expected_mats.size() == 0);
		hold_off = 0;
		for (int i = 0; i < 250; i++)
			pending_items.push_back(rand_item());
		wait (pending_items.size() == 0 && !start);

		wait (expected_mats.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
		if (n_errors == 0)
			$display("trs_local_matrix_builder: match");
		else
			$display("trs_local_matrix_builder: mismatch");
		$finish;
	end

endmodule
